FILE: rtl/scgs_pkg.sv
// Package for the subgrid-to-grid scatter convolution block.
// Beat types, opcodes and config register indexes. No dependencies.
package scgs_pkg;

  localparam logic [1:0] OP_KWR  = 2'd0;
  localparam logic [1:0] OP_SCAT = 2'd1;
  localparam logic [1:0] OP_GRD  = 2'd2;
  localparam logic [1:0] OP_GWR  = 2'd3;

  localparam logic [2:0] REG_GSX = 3'd0;
  localparam logic [2:0] REG_GSY = 3'd1;
  localparam logic [2:0] REG_GSZ = 3'd2;
  localparam logic [2:0] REG_KSX = 3'd3;
  localparam logic [2:0] REG_KSY = 3'd4;
  localparam logic [2:0] REG_KSZ = 3'd5;
  localparam logic [2:0] REG_SHK = 3'd6;

  typedef struct packed {
    logic [1:0]         op;
    logic [1:0]         batch;
    logic [2:0]         channel;
    logic [3:0]         pos_x;
    logic [3:0]         pos_y;
    logic [3:0]         pos_z;
    logic [3:0]         corner_x;
    logic [3:0]         corner_y;
    logic [3:0]         corner_z;
    logic signed [31:0] value_re;
    logic signed [31:0] value_im;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] grid_re;
    logic signed [31:0] grid_im;
  } out_beat_t;

  // multiply-accumulate unit control
  typedef struct packed {
    logic              mul;
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic [1:0]        term;
  } mac_ctl_t;

endpackage

FILE: rtl/scgs_mac.sv
// Shared complex MAC unit: one 16x16 product per cycle, four products per tap,
// then round and saturating add into the cell. Depends on scgs_pkg.
module scgs_mac (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scgs_pkg::mac_ctl_t  ctl_i,
  input  logic signed [31:0]  cell_re_i,
  input  logic signed [31:0]  cell_im_i,
  output logic signed [31:0]  sum_re_o,
  output logic signed [31:0]  sum_im_o
);
  logic signed [31:0] prod_q, prod_d;
  logic signed [33:0] acc_re_q, acc_re_d, acc_im_q, acc_im_d;
  logic [1:0]         term_q;
  logic               pv_q;

  assign prod_d = ctl_i.a * ctl_i.b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= 1'b0;
      term_q <= '0;
    end else begin
      pv_q   <= ctl_i.mul;
      term_q <= ctl_i.term;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    acc_re_q <= acc_re_d;
    acc_im_q <= acc_im_d;
  end

  // terms: 0 sr*kr (re), 1 si*ki (re), 2 si*kr (im), 3 sr*ki (im, minus)
  always_comb begin
    acc_re_d = acc_re_q;
    acc_im_d = acc_im_q;
    if (pv_q) begin
      case (term_q)
        2'd0:    acc_re_d = 34'(prod_q);
        2'd1:    acc_re_d = acc_re_q + 34'(prod_q);
        2'd2:    acc_im_d = 34'(prod_q);
        default: acc_im_d = acc_im_q - 34'(prod_q);
      endcase
    end
  end

  function automatic logic signed [31:0] rnd_sat(input logic signed [33:0] p,
                                                 input logic signed [31:0] c);
    logic signed [33:0] r;
    logic signed [34:0] s;
    r = (p + 34'sd16384) >>> 15;
    s = 35'(c) + 35'(r);
    if (s > 35'sd2147483647) rnd_sat = 32'sh7fffffff;
    else if (s < -35'sd2147483648) rnd_sat = 32'sh80000000;
    else rnd_sat = s[31:0];
  endfunction

  assign sum_re_o = rnd_sat(acc_re_q, cell_re_i);
  assign sum_im_o = rnd_sat(acc_im_q, cell_im_i);
endmodule

FILE: rtl/subgrid_to_grid_scatter_convolution.sv
// Top level of the subgrid-to-grid scatter convolution block; depends on scgs_pkg, scgs_mac.
// Tap and grid writes pass through S_KWR or S_GWR, reads through S_RD0 and S_RD1; a scatter
// runs S_NXT and S_MOD for set-up and wrap reduction, then S_KRD to S_WB per kernel tap
// (single shared multiplier, grid port). A new command is taken in any cycle busy is low.
// done strobes once a read has passed S_RD0 and S_RD1; the receiver cannot stall it.
// Reset returns control to idle and config to its defaults; kernel and grid stores hold no reset.
module subgrid_to_grid_scatter_convolution #(
  parameter int MAX_BATCH    = 4,
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_GRID     = 16,
  parameter int MAX_KERNEL   = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  scgs_pkg::in_beat_t   in_i,
  output logic                 done,
  output scgs_pkg::out_beat_t  out_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i
);
  localparam int BW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int GW = $clog2(MAX_GRID);
  localparam int KW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int GS = $clog2(MAX_GRID + 1);
  localparam int KS = $clog2(MAX_KERNEL + 1);
  localparam int KD = MAX_BATCH * MAX_CHANNELS * MAX_KERNEL ** 3;
  localparam int GD = MAX_BATCH * MAX_GRID ** 3;
  localparam int KAW = $clog2(KD);
  localparam int GAW = $clog2(GD);

  localparam logic [3:0] S_IDLE = 4'd0, S_KWR = 4'd1, S_GWR = 4'd2, S_RD0 = 4'd3,
                         S_RD1 = 4'd4, S_KRD = 4'd5, S_GRD = 4'd6, S_M0 = 4'd7,
                         S_M1 = 4'd8, S_M2 = 4'd9, S_M3 = 4'd10, S_ACC = 4'd11,
                         S_WB = 4'd12, S_NXT = 4'd13, S_MOD = 4'd14;

  logic [3:0] st_q, st_d;
  scgs_pkg::in_beat_t it_q;
  logic [GS-1:0] gsx_q, gsy_q, gsz_q;
  logic [KS-1:0] ksx_q, ksy_q, ksz_q;
  logic shk_q;
  logic [KW-1:0] kx_q, ky_q, kz_q;
  logic [GW-1:0] gx_q, gy_q, gz_q, gx0_q, gy0_q;
  logic [7:0] wx_q, wy_q, wz_q;
  logic [2:0] sh_q;
  logic [31:0] kmem [KD];
  logic [63:0] gmem [GD];
  logic [31:0] krd_q;
  logic [63:0] grd_q;
  logic [KAW-1:0] ka;
  logic [GAW-1:0] ga;
  logic ok_k, ok_g, ok_s;
  logic signed [31:0] sre, sim;
  scgs_pkg::mac_ctl_t mc;
  logic done_q;

  function automatic logic [GS-1:0] csz(input logic [31:0] v, input logic [4:0] m,
                                         input int hi);
    logic [4:0] t;
    t = v[4:0] & m;
    if (t == 5'd0) csz = GS'(1);
    else if (32'(t) > hi) csz = GS'(hi);
    else csz = GS'(t);
  endfunction

  // unreduced start position along one axis: p + c + half*g - half
  function automatic logic [7:0] winit(input logic [3:0] p, input logic [3:0] c,
                                        input logic [KS-1:0] k, input logic [GS-1:0] g);
    logic [7:0] h;
    h = 8'(k >> 1);
    winit = 8'(p) + 8'(c) + 8'(h * 8'(g)) - h;
  endfunction

  // one restoring step of the reduction mod g, divisor shifted by s
  function automatic logic [7:0] mstep(input logic [7:0] v, input logic [GS-1:0] g,
                                        input logic [2:0] s);
    logic [15:0] d;
    d = 16'(g) << s;
    mstep = (16'(v) >= d) ? v - d[7:0] : v;
  endfunction

  function automatic logic [GW-1:0] winc(input logic [GW-1:0] v, input logic [GS-1:0] g);
    winc = (GS'(v) + GS'(1) >= g) ? '0 : GW'(v + GW'(1));
  endfunction

  assign cfg_ready_o = 1'b1;
  assign busy = (st_q != S_IDLE);
  assign done = done_q;
  assign out_o.grid_re = grd_q[31:0];
  assign out_o.grid_im = grd_q[63:32];
  assign ok_k = 32'(it_q.batch) < MAX_BATCH && 32'(it_q.channel) < MAX_CHANNELS &&
                32'(it_q.pos_x) < MAX_KERNEL && 32'(it_q.pos_y) < MAX_KERNEL &&
                32'(it_q.pos_z) < MAX_KERNEL;
  assign ok_g = 32'(it_q.batch) < MAX_BATCH && 32'(it_q.pos_x) < MAX_GRID &&
                32'(it_q.pos_y) < MAX_GRID && 32'(it_q.pos_z) < MAX_GRID;
  assign ok_s = 32'(it_q.batch) < MAX_BATCH && 32'(it_q.channel) < MAX_CHANNELS;
  assign sre = 32'(signed'(it_q.value_re[15:0]));
  assign sim = 32'(signed'(it_q.value_im[15:0]));

  always_comb begin
    logic [BW-1:0] kb;
    logic [KW-1:0] tx, ty, tz;
    kb = shk_q ? '0 : BW'(it_q.batch);
    tx = KW'(ksx_q - KS'(1) - KS'(kx_q));
    ty = KW'(ksy_q - KS'(1) - KS'(ky_q));
    tz = KW'(ksz_q - KS'(1) - KS'(kz_q));
    if (st_q == S_KWR) begin
      ka = KAW'((((32'(it_q.batch) * MAX_CHANNELS + 32'(it_q.channel)) * MAX_KERNEL +
            32'(it_q.pos_x)) * MAX_KERNEL + 32'(it_q.pos_y)) * MAX_KERNEL + 32'(it_q.pos_z));
    end else begin
      ka = KAW'((((32'(kb) * MAX_CHANNELS + 32'(it_q.channel)) * MAX_KERNEL + 32'(tx)) *
            MAX_KERNEL + 32'(ty)) * MAX_KERNEL + 32'(tz));
    end
    if (st_q == S_GWR || st_q == S_RD0) begin
      ga = GAW'(((32'(it_q.batch) * MAX_GRID + 32'(it_q.pos_x)) * MAX_GRID +
            32'(it_q.pos_y)) * MAX_GRID + 32'(it_q.pos_z));
    end else begin
      ga = GAW'(((32'(it_q.batch) * MAX_GRID + 32'(gx_q)) * MAX_GRID + 32'(gy_q)) *
            MAX_GRID + 32'(gz_q));
    end
  end

  always_comb begin
    mc = '0;
    case (st_q)
      S_M0: begin mc.mul = 1'b1; mc.a = sre[15:0]; mc.b = krd_q[15:0];  mc.term = 2'd0; end
      S_M1: begin mc.mul = 1'b1; mc.a = sim[15:0]; mc.b = krd_q[31:16]; mc.term = 2'd1; end
      S_M2: begin mc.mul = 1'b1; mc.a = sim[15:0]; mc.b = krd_q[15:0];  mc.term = 2'd2; end
      S_M3: begin mc.mul = 1'b1; mc.a = sre[15:0]; mc.b = krd_q[31:16]; mc.term = 2'd3; end
      default: mc = '0;
    endcase
  end

  logic signed [31:0] nre, nim;
  scgs_mac u_mac (
    .clk_i, .rst_ni, .ctl_i(mc), .cell_re_i(grd_q[31:0]), .cell_im_i(grd_q[63:32]),
    .sum_re_o(nre), .sum_im_o(nim)
  );

  always_ff @(posedge clk_i) begin
    if (st_q == S_KWR && ok_k) kmem[ka] <= {it_q.value_im[15:0], it_q.value_re[15:0]};
    if (st_q == S_GWR && ok_g) gmem[ga] <= {it_q.value_im, it_q.value_re};
    if (st_q == S_WB) gmem[ga] <= {nim, nre};
    krd_q <= kmem[ka];
    if (st_q == S_RD0 || st_q == S_GRD) grd_q <= gmem[ga];
    else if (st_q == S_RD1 && !ok_g) grd_q <= '0;
    if (st_q == S_IDLE && start) it_q <= in_i;
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (start) begin
        case (in_i.op)
          scgs_pkg::OP_KWR:  st_d = S_KWR;
          scgs_pkg::OP_GWR:  st_d = S_GWR;
          scgs_pkg::OP_GRD:  st_d = S_RD0;
          default:           st_d = S_NXT;
        endcase
      end
      S_KWR, S_GWR: st_d = S_IDLE;
      S_RD0: st_d = S_RD1;
      S_RD1: st_d = S_IDLE;
      S_KRD: st_d = S_GRD;
      S_GRD: st_d = S_M0;
      S_M0: st_d = S_M1;
      S_M1: st_d = S_M2;
      S_M2: st_d = S_M3;
      S_M3: st_d = S_ACC;
      S_ACC: st_d = S_WB;
      S_WB: begin
        if (KS'(kx_q) + KS'(1) == ksx_q && KS'(ky_q) + KS'(1) == ksy_q &&
            KS'(kz_q) + KS'(1) == ksz_q) st_d = S_IDLE;
        else st_d = S_KRD;
      end
      S_NXT: st_d = ok_s ? S_MOD : S_IDLE;
      S_MOD: st_d = (sh_q == 3'd0) ? S_KRD : S_MOD;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      done_q <= 1'b0;
      gsx_q <= GS'(MAX_GRID < 16 ? MAX_GRID : 16);
      gsy_q <= GS'(MAX_GRID < 16 ? MAX_GRID : 16);
      gsz_q <= GS'(MAX_GRID < 16 ? MAX_GRID : 16);
      ksx_q <= KS'(MAX_KERNEL < 3 ? MAX_KERNEL : 3);
      ksy_q <= KS'(MAX_KERNEL < 3 ? MAX_KERNEL : 3);
      ksz_q <= KS'(MAX_KERNEL < 3 ? MAX_KERNEL : 3);
      shk_q <= 1'b1;
      kx_q <= '0; ky_q <= '0; kz_q <= '0;
      gx_q <= '0; gy_q <= '0; gz_q <= '0; gx0_q <= '0; gy0_q <= '0;
      wx_q <= '0; wy_q <= '0; wz_q <= '0; sh_q <= '0;
    end else begin
      st_q <= st_d;
      done_q <= (st_q == S_RD1);
      if (cfg_valid_i) begin
        case (cfg_index_i)
          scgs_pkg::REG_GSX: gsx_q <= csz(cfg_data_i, 5'h1f, MAX_GRID);
          scgs_pkg::REG_GSY: gsy_q <= csz(cfg_data_i, 5'h1f, MAX_GRID);
          scgs_pkg::REG_GSZ: gsz_q <= csz(cfg_data_i, 5'h1f, MAX_GRID);
          scgs_pkg::REG_KSX: ksx_q <= KS'(csz(cfg_data_i, 5'h0f, MAX_KERNEL));
          scgs_pkg::REG_KSY: ksy_q <= KS'(csz(cfg_data_i, 5'h0f, MAX_KERNEL));
          scgs_pkg::REG_KSZ: ksz_q <= KS'(csz(cfg_data_i, 5'h0f, MAX_KERNEL));
          scgs_pkg::REG_SHK: shk_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (st_q == S_NXT) begin
        kx_q <= '0; ky_q <= '0; kz_q <= '0;
        wx_q <= winit(it_q.pos_x, it_q.corner_x, ksx_q, gsx_q);
        wy_q <= winit(it_q.pos_y, it_q.corner_y, ksy_q, gsy_q);
        wz_q <= winit(it_q.pos_z, it_q.corner_z, ksz_q, gsz_q);
        sh_q <= 3'd7;
      end else if (st_q == S_MOD) begin
        wx_q  <= mstep(wx_q, gsx_q, sh_q);
        wy_q  <= mstep(wy_q, gsy_q, sh_q);
        wz_q  <= mstep(wz_q, gsz_q, sh_q);
        sh_q  <= sh_q - 3'd1;
        gx_q  <= GW'(mstep(wx_q, gsx_q, sh_q));
        gx0_q <= GW'(mstep(wx_q, gsx_q, sh_q));
        gy_q  <= GW'(mstep(wy_q, gsy_q, sh_q));
        gy0_q <= GW'(mstep(wy_q, gsy_q, sh_q));
        gz_q  <= GW'(mstep(wz_q, gsz_q, sh_q));
      end else if (st_q == S_WB) begin
        if (KS'(kx_q) + KS'(1) != ksx_q) begin
          kx_q <= kx_q + KW'(1);
          gx_q <= winc(gx_q, gsx_q);
        end else begin
          kx_q <= '0;
          gx_q <= gx0_q;
          if (KS'(ky_q) + KS'(1) != ksy_q) begin
            ky_q <= ky_q + KW'(1);
            gy_q <= winc(gy_q, gsy_q);
          end else begin
            ky_q <= '0;
            gy_q <= gy0_q;
            kz_q <= kz_q + KW'(1);
            gz_q <= winc(gz_q, gsz_q);
          end
        end
      end
    end
  end

  a_done_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> $past(st_q) == S_RD1) else $error("done without read");
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("start not taken");
  a_wb_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_WB) |-> $past(st_q) == S_ACC) else $error("writeback out of order");
endmodule
